### rtl/spu_pkg.sv
package spu_pkg;

    localparam int MOTION_FRAC_BITS_DEF = 16;
    localparam int QUAT_FRAC_BITS_DEF   = 30;

    localparam logic [31:0] PERIOD_RST  = 32'd42949673;
    localparam logic [30:0] GRAVITY_RST = 31'd642690;
    localparam logic [31:0] QW_RST      = 32'h4000_0000;

    localparam int ADDR_W = 3;
    typedef enum logic [ADDR_W-1:0] {
        REG_PERIOD  = 3'd0,
        REG_GRAVITY = 3'd1,
        REG_QW      = 3'd2,
        REG_QX      = 3'd3,
        REG_QY      = 3'd4,
        REG_QZ      = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HALF,
        ST_ATT,
        ST_ROTP,
        ST_ACC,
        ST_VEL,
        ST_POS,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       load;
        logic       run;
        state_t     phase;
        logic [3:0] step;
        logic       emit;
    } cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) return -32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (x < -64'sh8000_0000_0000) return -48'sh8000_0000_0000;
        return x[47:0];
    endfunction

endpackage

### rtl/strapdown_pose_update_core.sv
// One sample in flight: a new input beat is accepted only once the previous
// result has been taken; one shared multiplier is stepped through half-angle,
// attitude, rotation, acceleration and integration terms.
// Reset (aresetn low, synchronous): registers to defaults, attitude to the
// start quaternion, motion state cleared.
module strapdown_pose_update_core #(
    parameter int MOTION_FRAC_BITS = spu_pkg::MOTION_FRAC_BITS_DEF,
    parameter int QUAT_FRAC_BITS   = spu_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // accel_x,y,z, rate_x,y,z
    input  logic         s_tuser,   // restart
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [383:0] m_tdata,   // att_w,x,y,z, vel_x,y,z, pos_x,y,z, pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import spu_pkg::*;

    logic [31:0] period_reg;
    logic [30:0] gravity_reg;
    logic [127:0] sq_reg;
    logic [ADDR_W-1:0] idx;
    logic busy, s_fire, m_fire;
    cmd_t cmd;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PERIOD_RST;
            gravity_reg <= GRAVITY_RST;
            sq_reg      <= {96'd0, QW_RST};
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_PERIOD:  period_reg <= pwdata;
                REG_GRAVITY: gravity_reg <= pwdata[30:0];
                REG_QW:      sq_reg[31:0] <= pwdata;
                REG_QX:      sq_reg[63:32] <= pwdata;
                REG_QY:      sq_reg[95:64] <= pwdata;
                REG_QZ:      sq_reg[127:96] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PERIOD:  prdata = period_reg;
            REG_GRAVITY: prdata = {1'b0, gravity_reg};
            REG_QW:      prdata = sq_reg[31:0];
            REG_QX:      prdata = sq_reg[63:32];
            REG_QY:      prdata = sq_reg[95:64];
            REG_QZ:      prdata = sq_reg[127:96];
            default:     prdata = '0;
        endcase
    end

    assign s_tready = !busy;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    spu_ctrl u_ctrl (
        .aclk, .aresetn, .s_fire, .m_fire, .busy,
        .out_valid(m_tvalid), .cmd
    );

    spu_dp #(.MOTION_FRAC_BITS(MOTION_FRAC_BITS), .QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_dp (
        .aclk, .aresetn, .cmd,
        .in_data(s_tdata), .in_restart(s_tuser),
        .period(period_reg), .gravity(gravity_reg), .start_q(sq_reg),
        .out_data(m_tdata)
    );
endmodule

### rtl/spu_ctrl.sv
module spu_ctrl (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_fire,
    input  logic        m_fire,
    output logic        busy,
    output logic        out_valid,
    output spu_pkg::cmd_t cmd
);
    import spu_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [3:0] last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_HALF: last = 4'd2;
            ST_ATT:  last = 4'd11;
            ST_ROTP: last = 4'd10;
            ST_ACC:  last = 4'd8;
            ST_VEL:  last = 4'd2;
            ST_POS:  last = 4'd2;
            default: last = 4'd0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.load   = 1'b0;
        cmd.run    = 1'b0;
        cmd.phase  = state_reg;
        cmd.step   = step_reg;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd.load   = 1'b1;
                    state_next = ST_HALF;
                    step_next  = '0;
                end
            end
            ST_OUT: begin
                if (m_fire) state_next = ST_IDLE;
            end
            default: begin
                cmd.run = 1'b1;
                if (step_reg == last) begin
                    step_next = '0;
                    unique case (state_reg)
                        ST_HALF: state_next = ST_ATT;
                        ST_ATT:  state_next = ST_ROTP;
                        ST_ROTP: state_next = ST_ACC;
                        ST_ACC:  state_next = ST_VEL;
                        ST_VEL:  state_next = ST_POS;
                        default: begin
                            state_next = ST_OUT;
                            cmd.emit   = 1'b1;
                        end
                    endcase
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    a_out_after_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POS && step_reg == 4'd2) |=> state_reg == ST_OUT)
        else $error("result not raised after position");
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !cmd.load) else $error("load while busy");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !m_fire) |=> out_valid) else $error("result dropped");
endmodule

### rtl/spu_dp.sv
module spu_dp #(
    parameter int MOTION_FRAC_BITS = spu_pkg::MOTION_FRAC_BITS_DEF,
    parameter int QUAT_FRAC_BITS   = spu_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  spu_pkg::cmd_t      cmd,
    input  logic [191:0]       in_data,
    input  logic               in_restart,
    input  logic [31:0]        period,
    input  logic [30:0]        gravity,
    input  logic [127:0]       start_q,
    output logic [383:0]       out_data
);
    import spu_pkg::*;

    localparam int HSH = 33 + MOTION_FRAC_BITS - QUAT_FRAC_BITS;

    logic signed [31:0] a_reg [3];
    logic signed [31:0] w_reg [3];
    logic signed [31:0] h_reg [3];
    logic signed [31:0] q_reg [4];
    logic signed [33:0] p_reg [10];
    logic signed [31:0] r_reg [9];
    logic signed [31:0] ia_reg [3];
    logic signed [31:0] ap_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] vp_reg [3];
    logic signed [47:0] x_reg [3];
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic signed [31:0] n_reg [4];

    // shared multiplier: 33 x 33 signed
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [63:0] qm;
    logic [1:0] k3;
    logic [1:0] n4;
    logic [1:0] sub3;

    assign prod = ma * mb;
    assign qm   = 64'(prod >>> QUAT_FRAC_BITS);

    // product index pairs for rotation
    function automatic logic [3:0] pa(input logic [3:0] s);
        unique case (s)
            4'd0: pa = 4'd0; 4'd1: pa = 4'd1; 4'd2: pa = 4'd2; 4'd3: pa = 4'd3;
            4'd4: pa = 4'd1; 4'd5: pa = 4'd1; 4'd6: pa = 4'd2;
            4'd7: pa = 4'd0; 4'd8: pa = 4'd0; default: pa = 4'd0;
        endcase
    endfunction
    function automatic logic [3:0] pb(input logic [3:0] s);
        unique case (s)
            4'd0: pb = 4'd0; 4'd1: pb = 4'd1; 4'd2: pb = 4'd2; 4'd3: pb = 4'd3;
            4'd4: pb = 4'd2; 4'd5: pb = 4'd3; 4'd6: pb = 4'd3;
            4'd7: pb = 4'd1; 4'd8: pb = 4'd2; default: pb = 4'd3;
        endcase
    endfunction

    // attitude term table: step = 3*n + k, h_k times q[qi], sign
    logic [1:0] att_qi;
    logic       att_neg;
    always_comb begin
        unique case (cmd.step)
            4'd0:    {n4, k3} = 4'b00_00;
            4'd1:    {n4, k3} = 4'b00_01;
            4'd2:    {n4, k3} = 4'b00_10;
            4'd3:    {n4, k3} = 4'b01_00;
            4'd4:    {n4, k3} = 4'b01_01;
            4'd5:    {n4, k3} = 4'b01_10;
            4'd6:    {n4, k3} = 4'b10_00;
            4'd7:    {n4, k3} = 4'b10_01;
            4'd8:    {n4, k3} = 4'b10_10;
            4'd9:    {n4, k3} = 4'b11_00;
            4'd10:   {n4, k3} = 4'b11_01;
            4'd11:   {n4, k3} = 4'b11_10;
            default: {n4, k3} = 4'b00_00;
        endcase
        sub3 = k3;
        unique case ({n4, k3})
            4'b00_00: begin att_qi = 2'd1; att_neg = 1'b1; end
            4'b00_01: begin att_qi = 2'd2; att_neg = 1'b1; end
            4'b00_10: begin att_qi = 2'd3; att_neg = 1'b1; end
            4'b01_00: begin att_qi = 2'd0; att_neg = 1'b0; end
            4'b01_01: begin att_qi = 2'd3; att_neg = 1'b1; end
            4'b01_10: begin att_qi = 2'd2; att_neg = 1'b0; end
            4'b10_00: begin att_qi = 2'd3; att_neg = 1'b0; end
            4'b10_01: begin att_qi = 2'd0; att_neg = 1'b0; end
            4'b10_10: begin att_qi = 2'd1; att_neg = 1'b1; end
            4'b11_00: begin att_qi = 2'd2; att_neg = 1'b1; end
            4'b11_01: begin att_qi = 2'd1; att_neg = 1'b0; end
            default:  begin att_qi = 2'd0; att_neg = 1'b0; end
        endcase
    end

    // half-dt integration: floor(x*dt/2^33), x 33 bits
    logic signed [32:0] isum;
    always_comb begin
        isum = '0;
        unique case (cmd.phase)
            ST_VEL: isum = 33'(ia_reg[sub3]) + 33'(ap_reg[sub3]);
            ST_POS: isum = 33'(v_reg[sub3]) + 33'(vp_reg[sub3]);
            default: isum = '0;
        endcase
    end

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (cmd.phase)
            ST_HALF: begin ma = 33'(w_reg[sub3]); mb = {1'b0, period}; end
            ST_ATT:  begin ma = 33'(h_reg[k3]); mb = 33'(q_reg[att_qi]); end
            ST_ROTP: begin ma = 33'(q_reg[2'(pa(cmd.step))]);
                           mb = 33'(q_reg[2'(pb(cmd.step))]); end
            ST_ACC:  begin ma = 33'(r_reg[cmd.step]); mb = 33'(a_reg[k3]); end
            ST_VEL, ST_POS: begin ma = isum; mb = {1'b0, period}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    logic signed [63:0] dtv;
    assign dtv = 64'(prod >>> 33);

    // rotation entries from products: ww xx yy zz xy xz yz wx wy wz
    function automatic logic signed [31:0] rent(input logic [3:0] e,
        input logic signed [33:0] p [10]);
        logic signed [63:0] v;
        unique case (e)
            4'd0: v = 64'(p[0]) + p[1] - p[2] - p[3];
            4'd1: v = 2 * (64'(p[4]) - p[9]);
            4'd2: v = 2 * (64'(p[5]) + p[8]);
            4'd3: v = 2 * (64'(p[4]) + p[9]);
            4'd4: v = 64'(p[0]) - p[1] + p[2] - p[3];
            4'd5: v = 2 * (64'(p[6]) - p[7]);
            4'd6: v = 2 * (64'(p[5]) - p[8]);
            4'd7: v = 2 * (64'(p[6]) + p[7]);
            default: v = 64'(p[0]) - p[1] - p[2] + p[3];
        endcase
        return sat32(v);
    endfunction

    always_comb begin
        acc_next = acc_reg;
        unique case (cmd.phase)
            ST_ATT:  acc_next = (k3 == 2'd0 ? 64'(q_reg[n4]) : acc_reg)
                                + (att_neg ? -qm : qm);
            ST_ACC:  acc_next = (k3 == 2'd0 ? 64'sd0 : acc_reg) + qm;
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[0] <= QW_RST;
            for (int i = 1; i < 4; i++) q_reg[i] <= '0;
            for (int i = 0; i < 3; i++) begin
                ia_reg[i] <= '0; v_reg[i] <= '0; x_reg[i] <= '0;
            end
        end else begin
            if (cmd.load) begin
                for (int i = 0; i < 3; i++) begin
                    a_reg[i] <= in_data[32*i +: 32];
                    w_reg[i] <= in_data[96 + 32*i +: 32];
                end
                if (in_restart) begin
                    for (int i = 0; i < 4; i++) q_reg[i] <= start_q[32*i +: 32];
                    for (int i = 0; i < 3; i++) begin
                        ia_reg[i] <= '0; v_reg[i] <= '0; x_reg[i] <= '0;
                    end
                end
            end
            if (cmd.run) begin
                acc_reg <= acc_next;
                unique case (cmd.phase)
                    ST_HALF: h_reg[sub3] <= sat32(64'(prod >>> HSH));
                    ST_ATT: begin
                        if (k3 == 2'd2) n_reg[n4] <= sat32(acc_next);
                        if (cmd.step == 4'd11) begin
                            for (int i = 0; i < 3; i++) q_reg[i] <= n_reg[i];
                            q_reg[3] <= sat32(acc_next);
                        end
                    end
                    ST_ROTP: begin
                        if (cmd.step == 4'd10)
                            for (int e = 0; e < 9; e++) r_reg[e] <= rent(4'(e), p_reg);
                        else
                            p_reg[cmd.step] <= qm[33:0];
                    end
                    ST_ACC: begin
                        if (k3 == 2'd2) begin
                            ap_reg[n4] <= ia_reg[n4];
                            ia_reg[n4] <= sat32(n4 == 2'd2 ?
                                acc_next - 64'({1'b0, gravity}) : acc_next);
                        end
                    end
                    ST_VEL: begin
                        vp_reg[sub3] <= v_reg[sub3];
                        v_reg[sub3]  <= sat32(64'(v_reg[sub3]) + dtv);
                    end
                    ST_POS: x_reg[sub3] <= sat48(64'(x_reg[sub3]) + dtv);
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) out_data[32*i +: 32] = q_reg[i];
        for (int i = 0; i < 3; i++) out_data[128 + 32*i +: 32] = v_reg[i];
        for (int i = 0; i < 3; i++) out_data[224 + 48*i +: 48] = x_reg[i];
        out_data[383:368] = '0;
    end

    logic unused_emit;
    assign unused_emit = cmd.emit;
endmodule
